[rtl/core/srrhm_pkg.sv]
// shared types, constants and helpers for the sensor range and rate health monitor
package srrhm_pkg;

    // number of value slots a sample can carry
    localparam int unsigned SIGNAL_SLOTS = 2;

    // field widths
    localparam int unsigned VALUE_W = 32;
    localparam int unsigned STAMP_W = 63;
    localparam int unsigned DT_W    = 40;
    localparam int unsigned DV_W    = VALUE_W + 1;
    localparam int unsigned CFG_W   = 32;
    localparam int unsigned CIDX_W  = 3;
    localparam int unsigned DT_HALF = DT_W / 2;

    // nanoseconds per second and the dt saturation point
    localparam logic [29:0]     NS_PER_S = 30'd1_000_000_000;
    localparam logic [DT_W-1:0] DT_MAX   = {DT_W{1'b1}};

    // health codes
    typedef enum logic [1:0] {
        ST_LIVE    = 2'd0,
        ST_FAULTY  = 2'd1,
        ST_INVALID = 2'd2,
        ST_DEAD    = 2'd3
    } health_t;

    // request codes
    typedef enum logic {
        REQ_SAMPLE = 1'b0,
        REQ_TICK   = 1'b1
    } req_t;

    // configuration register indexes
    typedef enum logic [CIDX_W-1:0] {
        CFG_RANGE_LOW_A  = 3'd0,
        CFG_RANGE_HIGH_A = 3'd1,
        CFG_RATE_LIMIT_A = 3'd2,
        CFG_RANGE_LOW_B  = 3'd3,
        CFG_RANGE_HIGH_B = 3'd4,
        CFG_RATE_LIMIT_B = 3'd5,
        CFG_STALE_TICKS  = 3'd6,
        CFG_SIGNALS_USED = 3'd7
    } cfg_idx_t;

    // a count code of three acts as the full slot count
    function automatic logic [1:0] clamp_slots(input logic [1:0] c);
        logic [1:0] r;
        r = c;
        if (32'(c) > SIGNAL_SLOTS)
        begin
            r = 2'(SIGNAL_SLOTS);
        end
        return r;
    endfunction

endpackage

[rtl/core/sensor_range_rate_health_monitor.sv]
// sensor range and rate health monitor, one sensor channel
//
// Usage: each input transfer is either a sample (req_type 0: value_a, value_b,
// value_count, sample_stamp) or a tick (req_type 1) that marks one unit of time.
// Every input transfer yields exactly one output transfer carrying health,
// range_fault and rate_fault, in input order.
// Channels use valid/stall; a transfer happens when valid is high and stall
// is low. Configuration registers are written through cfg_we/cfg_index/
// cfg_data, one register per cycle, while the block is idle.
// Each item passes in order through the input register, range/reference stage,
// product stage and result register; a stall can hold it in any of them.
// Throughput: one item per cycle until a receiver stall fills every stage; the
// reference state is updated in the range stage, so the next item already sees
// it, and the two rate multiplications per signal run one stage later.
// Reset: the configuration takes its default values, no reference exists and
// tick results report dead until the first sample has been seen.
// When the receiver stalls, the result holds and bubbles ahead of it fill;
// input stall rises only once every stage holds an item.
module sensor_range_rate_health_monitor
    import srrhm_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    // configuration write port
    input  logic                      cfg_we,
    input  logic [CIDX_W-1:0]         cfg_index,
    input  logic [CFG_W-1:0]          cfg_data,
    // input channel
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic                      req_type,
    input  logic signed [VALUE_W-1:0] value_a,
    input  logic signed [VALUE_W-1:0] value_b,
    input  logic [1:0]                value_count,
    input  logic [STAMP_W-1:0]        sample_stamp,
    // output channel
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [1:0]                health,
    output logic                      range_fault,
    output logic                      rate_fault
);

    // configuration registers
    logic signed [VALUE_W-1:0] range_low_reg  [2];
    logic signed [VALUE_W-1:0] range_high_reg [2];
    logic [CFG_W-1:0]          rate_limit_reg [2];
    logic [CFG_W-1:0]          stale_ticks_reg;
    logic [1:0]                signals_used_reg;

    // monitor state
    logic signed [VALUE_W-1:0] ref_value_reg [2];
    logic [1:0]                ref_count_reg;
    logic [STAMP_W-1:0]        ref_stamp_reg;
    logic                      ref_valid_reg;
    logic                      seen_sample_reg;
    logic [31:0]               age_ticks_reg;
    health_t                   last_status_reg;

    // stage 0: input register
    logic                      s0_valid_reg;
    logic                      s0_req_reg;
    logic signed [VALUE_W-1:0] s0_value_reg [2];
    logic [1:0]                s0_count_reg;
    logic [STAMP_W-1:0]        s0_stamp_reg;

    // stage 1: range and reference results
    logic                      s1_valid_reg;
    logic                      s1_req_reg;
    logic                      s1_dead_reg;
    logic                      s1_oor_reg;
    logic                      s1_chk_reg [2];
    logic [DV_W-1:0]           s1_dv_reg  [2];
    logic [DT_W-1:0]           s1_dt_reg;

    // stage 2: partial products
    logic                      s2_valid_reg;
    logic                      s2_req_reg;
    logic                      s2_dead_reg;
    logic                      s2_oor_reg;
    logic                      s2_chk_reg  [2];
    logic                      s2_dvh_reg  [2];
    logic [61:0]               s2_lhs_reg  [2];
    logic [CFG_W+DT_HALF-1:0]  s2_rhi_reg  [2];
    logic [CFG_W+DT_HALF-1:0]  s2_rlo_reg  [2];

    // stage 3: result register
    logic                      out_valid_reg;
    health_t                   health_reg;
    logic                      range_fault_reg;
    logic                      rate_fault_reg;

    // stage advance
    logic adv1, adv2, adv3, in_xfer;

    assign adv3    = s2_valid_reg && (!out_valid_reg || !out_stall);
    assign adv2    = s1_valid_reg && (!s2_valid_reg || adv3);
    assign adv1    = s0_valid_reg && (!s1_valid_reg || adv2);
    assign in_stall = s0_valid_reg && !adv1;
    assign in_xfer  = in_valid && !in_stall;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_low_reg[0]  <= {1'b1, {(VALUE_W-1){1'b0}}};
            range_high_reg[0] <= {1'b0, {(VALUE_W-1){1'b1}}};
            rate_limit_reg[0] <= {CFG_W{1'b1}};
            range_low_reg[1]  <= {1'b1, {(VALUE_W-1){1'b0}}};
            range_high_reg[1] <= {1'b0, {(VALUE_W-1){1'b1}}};
            rate_limit_reg[1] <= {CFG_W{1'b1}};
            stale_ticks_reg   <= 32'd1000;
            signals_used_reg  <= 2'(SIGNAL_SLOTS);
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_RANGE_LOW_A:  range_low_reg[0]  <= cfg_data;
                CFG_RANGE_HIGH_A: range_high_reg[0] <= cfg_data;
                CFG_RATE_LIMIT_A: rate_limit_reg[0] <= cfg_data;
                CFG_RANGE_LOW_B:  range_low_reg[1]  <= cfg_data;
                CFG_RANGE_HIGH_B: range_high_reg[1] <= cfg_data;
                CFG_RATE_LIMIT_B: rate_limit_reg[1] <= cfg_data;
                CFG_STALE_TICKS:  stale_ticks_reg   <= cfg_data;
                CFG_SIGNALS_USED: signals_used_reg  <= cfg_data[1:0];
                default:          stale_ticks_reg   <= stale_ticks_reg;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
        end
        else if (in_xfer)
        begin
            s0_valid_reg <= 1'b1;
        end
        else if (adv1)
        begin
            s0_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s0_req_reg      <= req_type;
            s0_value_reg[0] <= value_a;
            s0_value_reg[1] <= value_b;
            s0_count_reg    <= value_count;
            s0_stamp_reg    <= sample_stamp;
        end
    end

    // stage 1 logic: slot count, dt, range check, value deltas
    logic [1:0]         cnt, su, n_chk;
    logic [STAMP_W:0]   stamp_diff;
    logic [DT_W-1:0]    dt;
    logic               dt_ok;
    logic               lane_oor [2];
    logic               lane_chk [2];
    logic signed [DV_W-1:0] lane_d [2];
    logic [DV_W-1:0]    lane_dv  [2];
    logic               oor;
    logic [31:0]        age_next;
    logic               dead_next;

    always_comb
    begin
        cnt   = clamp_slots(s0_count_reg);
        su    = clamp_slots(signals_used_reg);
        n_chk = (cnt < su) ? cnt : su;

        // stamp difference, saturated; rate check skipped unless the stamp is at least two ahead
        stamp_diff = {1'b0, s0_stamp_reg} - {1'b0, ref_stamp_reg};
        if (|stamp_diff[STAMP_W-1:DT_W])
        begin
            dt = DT_MAX;
        end
        else
        begin
            dt = stamp_diff[DT_W-1:0];
        end
        dt_ok = ref_valid_reg && !stamp_diff[STAMP_W] && (dt > DT_W'(1));

        oor = 1'b0;
        for (int i = 0; i < 2; i++)
        begin
            lane_oor[i] = (2'(i) < n_chk) &&
                          ((s0_value_reg[i] < range_low_reg[i]) ||
                           (s0_value_reg[i] > range_high_reg[i]));
            lane_chk[i] = (2'(i) < n_chk) && dt_ok && (2'(i) < ref_count_reg);
            lane_d[i]   = {s0_value_reg[i][VALUE_W-1], s0_value_reg[i]} -
                          {ref_value_reg[i][VALUE_W-1], ref_value_reg[i]};
            lane_dv[i]  = lane_d[i][DV_W-1] ? DV_W'(-lane_d[i]) : DV_W'(lane_d[i]);
            oor         = oor | lane_oor[i];
        end

        // tick ageing and dead decision
        age_next  = (age_ticks_reg == 32'hFFFF_FFFF) ? age_ticks_reg : age_ticks_reg + 32'd1;
        dead_next = !seen_sample_reg || (age_next > stale_ticks_reg);
    end

    // monitor state update as an item leaves the input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_value_reg[0] <= '0;
            ref_value_reg[1] <= '0;
            ref_count_reg    <= '0;
            ref_stamp_reg    <= '0;
            ref_valid_reg    <= 1'b0;
            seen_sample_reg  <= 1'b0;
            age_ticks_reg    <= '0;
        end
        else if (adv1)
        begin
            if (s0_req_reg == REQ_TICK)
            begin
                age_ticks_reg <= age_next;
            end
            else
            begin
                seen_sample_reg <= 1'b1;
                age_ticks_reg   <= '0;
                if (!oor)
                begin
                    ref_value_reg[0] <= s0_value_reg[0];
                    ref_value_reg[1] <= s0_value_reg[1];
                    ref_count_reg    <= cnt;
                    ref_stamp_reg    <= s0_stamp_reg;
                    ref_valid_reg    <= 1'b1;
                end
            end
        end
    end

    // stage 1 registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (adv1)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (adv2)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            s1_req_reg  <= s0_req_reg;
            s1_dead_reg <= dead_next;
            s1_oor_reg  <= oor;
            s1_dt_reg   <= dt;
            for (int i = 0; i < 2; i++)
            begin
                s1_chk_reg[i] <= lane_chk[i];
                s1_dv_reg[i]  <= lane_dv[i];
            end
        end
    end

    // stage 2: |dv| times 1e9 and rate times dt in two halves
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (adv2)
        begin
            s2_valid_reg <= 1'b1;
        end
        else if (adv3)
        begin
            s2_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv2)
        begin
            s2_req_reg  <= s1_req_reg;
            s2_dead_reg <= s1_dead_reg;
            s2_oor_reg  <= s1_oor_reg;
            for (int i = 0; i < 2; i++)
            begin
                s2_chk_reg[i] <= s1_chk_reg[i];
                s2_dvh_reg[i] <= s1_dv_reg[i][DV_W-1];
                s2_lhs_reg[i] <= 62'(s1_dv_reg[i][VALUE_W-1:0]) * 62'(NS_PER_S);
                s2_rhi_reg[i] <= (CFG_W+DT_HALF)'(rate_limit_reg[i]) *
                                 (CFG_W+DT_HALF)'(s1_dt_reg[DT_W-1:DT_HALF]);
                s2_rlo_reg[i] <= (CFG_W+DT_HALF)'(rate_limit_reg[i]) *
                                 (CFG_W+DT_HALF)'(s1_dt_reg[DT_HALF-1:0]);
            end
        end
    end

    // stage 3 logic: assemble both sides and compare
    logic [63:0]               lhs  [2];
    logic [CFG_W+DT_W-1:0]     rhs  [2];
    logic                      viol;
    health_t                   status;

    always_comb
    begin
        viol = 1'b0;
        for (int i = 0; i < 2; i++)
        begin
            lhs[i] = 64'(s2_lhs_reg[i]) +
                     (s2_dvh_reg[i] ? (64'(NS_PER_S) << VALUE_W) : 64'd0);
            rhs[i] = {s2_rhi_reg[i], {DT_HALF{1'b0}}} + (CFG_W+DT_W)'(s2_rlo_reg[i]);
            viol   = viol | (s2_chk_reg[i] && ((CFG_W+DT_W)'(lhs[i]) > rhs[i]));
        end
        if (s2_oor_reg)
        begin
            status = ST_INVALID;
        end
        else if (viol)
        begin
            status = ST_FAULTY;
        end
        else
        begin
            status = ST_LIVE;
        end
    end

    // result register and last sample status
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg   <= 1'b0;
            last_status_reg <= ST_LIVE;
        end
        else
        begin
            if (adv3)
            begin
                out_valid_reg <= 1'b1;
                if (s2_req_reg == REQ_SAMPLE)
                begin
                    last_status_reg <= status;
                end
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv3)
        begin
            if (s2_req_reg == REQ_TICK)
            begin
                health_reg      <= s2_dead_reg ? ST_DEAD : last_status_reg;
                range_fault_reg <= 1'b0;
                rate_fault_reg  <= 1'b0;
            end
            else
            begin
                health_reg      <= status;
                range_fault_reg <= s2_oor_reg;
                rate_fault_reg  <= viol;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign health      = health_reg;
    assign range_fault = range_fault_reg;
    assign rate_fault  = rate_fault_reg;

    // a range fault always reports invalid
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && range_fault |-> health == ST_INVALID)
        else $error("range fault without invalid health");

    // a rate fault alone reports faulty
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && rate_fault && !range_fault |-> health == ST_FAULTY)
        else $error("rate fault without faulty health");

    // dead results carry no fault flags
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && health == ST_DEAD |-> !range_fault && !rate_fault)
        else $error("dead result with fault flag");

    // an out of range sample leaves the reference stamp alone
    assert property (@(posedge clk) disable iff (!rst_n)
        adv1 && s0_req_reg == REQ_SAMPLE && oor |=> $stable(ref_stamp_reg))
        else $error("reference updated by out of range sample");

    // an empty input register never stalls the sender
    assert property (@(posedge clk) disable iff (!rst_n)
        !s0_valid_reg |-> !in_stall)
        else $error("input stalled with empty input register");

endmodule
